/* rtl/ded_pkg.sv */
`timescale 1ns / 1ps

package ded_pkg;

    localparam int DAY_W      = 5;
    localparam int MONTH_W    = 4;
    localparam int YEAR_W     = 14;
    localparam int STATUS_W   = 2;
    localparam int AGO_W      = 22;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;
    localparam int DOY_W      = 9;
    localparam int Q100_W     = 8;
    localparam int C400_W     = 6;
    localparam int LEAPS_W    = 13;
    localparam int FDAY_W     = 7;
    localparam int FMON_W     = 5;
    localparam int SUM_W      = 25;

    localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd1800;
    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

    localparam logic [DAY_W-1:0]   RST_TODAY_DAY   = 5'd1;
    localparam logic [MONTH_W-1:0] RST_TODAY_MONTH = 4'd1;
    localparam logic [YEAR_W-1:0]  RST_TODAY_YEAR  = 14'd2000;

    localparam logic [AGO_W-1:0] AGO_MAX = 22'h3FFFFF;

    // floor(x / 100) as (x * 5243) >> 19, exact for x below 16500
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;

    typedef enum logic [STATUS_W-1:0] {
        ST_INVALID = 2'd0,
        ST_EXPIRED = 2'd1,
        ST_TODAY   = 2'd2,
        ST_LATER   = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TODAY_DAY   = 2'd0,
        CFG_TODAY_MONTH = 2'd1,
        CFG_TODAY_YEAR  = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } today_t;

    typedef struct packed {
        logic                ok;
        logic                earlier;
        logic                same;
        logic [DOY_W-1:0]    doy_e;
        logic [DOY_W-1:0]    doy_t;
        logic [YEAR_W-1:0]   yr_span;
        logic [LEAPS_W-1:0]  leap_days;
        logic [FDAY_W-1:0]   fday;
        logic [FMON_W-1:0]   fmon;
        logic [YEAR_W-1:0]   fyears;
    } cal_t;

    function automatic logic [Q100_W-1:0] div100(input logic [YEAR_W:0] x);
        logic [27:0] p;
        p = 28'(x) * 28'(DIV100_MUL);
        return p[DIV100_SHIFT +: Q100_W];
    endfunction

    function automatic logic is_leap(input logic [YEAR_W-1:0] y,
                                     input logic [Q100_W-1:0] q);
        logic rz;
        rz = (15'(y) == 15'(q) * 15'd100);
        return ((y[1:0] == 2'd0) && !rz) || (rz && (q[1:0] == 2'd0));
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // days in months 1 .. m-1 of a common year
    function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] c;
        unique case (m)
            4'd0:  c = 9'd0;
            4'd1:  c = 9'd0;
            4'd2:  c = 9'd31;
            4'd3:  c = 9'd59;
            4'd4:  c = 9'd90;
            4'd5:  c = 9'd120;
            4'd6:  c = 9'd151;
            4'd7:  c = 9'd181;
            4'd8:  c = 9'd212;
            4'd9:  c = 9'd243;
            4'd10: c = 9'd273;
            4'd11: c = 9'd304;
            4'd12: c = 9'd334;
            4'd13: c = 9'd365;
            4'd14: c = 9'd396;
            default: c = 9'd427;
        endcase
        return c;
    endfunction

endpackage

/* rtl/ded_cfg.sv */
`timescale 1ns / 1ps

module ded_cfg
    import ded_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output today_t                today
);

    today_t today_reg;
    today_t today_next;

    always_comb
    begin
        today_next = today_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TODAY_DAY:   today_next.day   = cfg_data[DAY_W-1:0];
                CFG_TODAY_MONTH: today_next.month = cfg_data[MONTH_W-1:0];
                CFG_TODAY_YEAR:  today_next.year  = cfg_data[YEAR_W-1:0];
                default:         today_next = today_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            today_reg.day   <= RST_TODAY_DAY;
            today_reg.month <= RST_TODAY_MONTH;
            today_reg.year  <= RST_TODAY_YEAR;
        end
        else
        begin
            today_reg <= today_next;
        end
    end

    assign today = today_reg;

endmodule

/* rtl/ded_calendar.sv */
`timescale 1ns / 1ps

module ded_calendar
    import ded_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                in_valid,
    input  logic [DAY_W-1:0]    expiry_day,
    input  logic [MONTH_W-1:0]  expiry_month,
    input  logic [YEAR_W-1:0]   expiry_year,
    input  today_t              today,
    output logic                cal_valid,
    output cal_t                cal
);

    // stage 1: quotients by 100
    logic                s1_valid_reg;
    logic [DAY_W-1:0]    s1_day_reg;
    logic [MONTH_W-1:0]  s1_month_reg;
    logic [YEAR_W-1:0]   s1_year_reg;
    logic [Q100_W-1:0]   s1_qy_reg;
    logic [Q100_W-1:0]   s1_qt_reg;
    logic [Q100_W-1:0]   s1_cy_reg;
    logic [Q100_W-1:0]   s1_ct_reg;

    logic [Q100_W-1:0]   qy_next;
    logic [Q100_W-1:0]   qt_next;
    logic [Q100_W-1:0]   cy_next;
    logic [Q100_W-1:0]   ct_next;

    always_comb
    begin
        qy_next = div100({1'b0, expiry_year});
        qt_next = div100({1'b0, today.year});
        cy_next = div100(15'(expiry_year) + 15'd99);
        ct_next = div100(15'(today.year) + 15'd99);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_day_reg   <= expiry_day;
            s1_month_reg <= expiry_month;
            s1_year_reg  <= expiry_year;
            s1_qy_reg    <= qy_next;
            s1_qt_reg    <= qt_next;
            s1_cy_reg    <= cy_next;
            s1_ct_reg    <= ct_next;
        end
    end

    // stage 2: leap years, validity, ordering, day of year, day borrow
    logic  s2_valid_reg;
    cal_t  s2_reg;
    cal_t  s2_next;

    always_comb
    begin
        logic                 leap_e;
        logic                 leap_t;
        logic [LEAPS_W-1:0]   c4y;
        logic [LEAPS_W-1:0]   c4t;
        logic [C400_W-1:0]    c400y;
        logic [C400_W-1:0]    c400t;
        logic [FDAY_W-1:0]    fd;
        logic signed [FMON_W-1:0] mon;
        logic signed [FMON_W-1:0] prev;

        leap_e = is_leap(s1_year_reg, s1_qy_reg);
        leap_t = is_leap(today.year, s1_qt_reg);

        s2_next.ok = (s1_year_reg >= YEAR_MIN) && (s1_year_reg <= YEAR_MAX)
                     && (s1_month_reg >= 4'd1) && (s1_month_reg <= 4'd12)
                     && (s1_day_reg >= 5'd1)
                     && (s1_day_reg <= month_len(s1_month_reg, leap_e));

        s2_next.earlier = (s1_year_reg < today.year)
            || ((s1_year_reg == today.year) && (s1_month_reg < today.month))
            || ((s1_year_reg == today.year) && (s1_month_reg == today.month)
                && (s1_day_reg < today.day));
        s2_next.same = (s1_year_reg == today.year) && (s1_month_reg == today.month)
                       && (s1_day_reg == today.day);

        s2_next.doy_e = cum_days(s1_month_reg) + DOY_W'(s1_day_reg)
                        + DOY_W'(leap_e && (s1_month_reg >= 4'd3));
        s2_next.doy_t = cum_days(today.month) + DOY_W'(today.day)
                        + DOY_W'(leap_t && (today.month >= 4'd3));

        // leap days between the two years: ceil(y/4) - ceil(y/100) + ceil(y/400)
        c4y   = LEAPS_W'((15'(s1_year_reg) + 15'd3) >> 2);
        c4t   = LEAPS_W'((15'(today.year) + 15'd3) >> 2);
        c400y = C400_W'((9'(s1_cy_reg) + 9'd3) >> 2);
        c400t = C400_W'((9'(s1_ct_reg) + 9'd3) >> 2);

        if (today.year > s1_year_reg)
        begin
            s2_next.yr_span   = today.year - s1_year_reg;
            s2_next.leap_days = (c4t - c4y)
                                - (LEAPS_W'(s1_ct_reg) - LEAPS_W'(s1_cy_reg))
                                + (LEAPS_W'(c400t) - LEAPS_W'(c400y));
        end
        else
        begin
            s2_next.yr_span   = '0;
            s2_next.leap_days = '0;
        end

        // borrow up to two preceding months while the day is short
        fd   = FDAY_W'(s1_day_reg);
        mon  = $signed({1'b0, s1_month_reg});
        prev = '0;
        for (int k = 0; k < 2; k++)
        begin
            if (fd < FDAY_W'(today.day))
            begin
                prev = (mon <= 5'sd1) ? (mon + 5'sd11) : (mon - 5'sd1);
                fd   = fd + FDAY_W'(month_len(prev[MONTH_W-1:0], leap_e));
                mon  = mon - 5'sd1;
            end
        end
        s2_next.fday   = fd;
        s2_next.fmon   = mon;
        s2_next.fyears = s1_year_reg - today.year;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_reg <= s2_next;
        end
    end

    assign cal_valid = s2_valid_reg;
    assign cal       = s2_reg;

endmodule

/* rtl/ded_diff.sv */
`timescale 1ns / 1ps

module ded_diff
    import ded_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 cal_valid,
    input  cal_t                 cal,
    input  today_t               today,
    output logic                 out_valid,
    output logic [STATUS_W-1:0]  status,
    output logic [AGO_W-1:0]     days_ago,
    output logic [DAY_W-1:0]     diff_days,
    output logic [MONTH_W-1:0]   diff_months,
    output logic [YEAR_W-1:0]    diff_years
);

    // stage 3: day count sum and year/month split
    logic                 s3_valid_reg;
    logic                 s3_ok_reg;
    logic                 s3_earlier_reg;
    logic                 s3_same_reg;
    logic [SUM_W-1:0]     s3_sum_reg;
    logic [DAY_W-1:0]     s3_dd_reg;
    logic [MONTH_W-1:0]   s3_dm_reg;
    logic [YEAR_W-1:0]    s3_dy_reg;

    logic [SUM_W-1:0]     sum_next;
    logic [DAY_W-1:0]     dd_next;
    logic [MONTH_W-1:0]   dm_next;
    logic [YEAR_W-1:0]    dy_next;

    always_comb
    begin
        logic signed [5:0]        delta;
        logic signed [YEAR_W:0]   fy;
        logic signed [YEAR_W:0]   yadj;
        logic signed [5:0]        mrem;

        sum_next = SUM_W'(cal.yr_span) * SUM_W'(365) + SUM_W'(cal.leap_days)
                   + SUM_W'(cal.doy_t) - SUM_W'(cal.doy_e);

        if (cal.fday >= FDAY_W'(today.day))
        begin
            dd_next = DAY_W'(cal.fday - FDAY_W'(today.day));
        end
        else
        begin
            dd_next = '0;
        end

        delta = 6'($signed(cal.fmon)) - $signed({2'b00, today.month});
        fy    = $signed({1'b0, cal.fyears});
        if (delta >= 6'sd12)
        begin
            mrem = delta - 6'sd12;
            yadj = fy + 15'sd1;
        end
        else if (delta >= 6'sd0)
        begin
            mrem = delta;
            yadj = fy;
        end
        else if (delta >= -6'sd12)
        begin
            mrem = delta + 6'sd12;
            yadj = fy - 15'sd1;
        end
        else
        begin
            mrem = delta + 6'sd24;
            yadj = fy - 15'sd2;
        end

        if (yadj < 0)
        begin
            dm_next = '0;
            dy_next = '0;
        end
        else
        begin
            dm_next = mrem[MONTH_W-1:0];
            dy_next = yadj[YEAR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s3_valid_reg <= cal_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_ok_reg      <= cal.ok;
            s3_earlier_reg <= cal.earlier;
            s3_same_reg    <= cal.same;
            s3_sum_reg     <= sum_next;
            s3_dd_reg      <= dd_next;
            s3_dm_reg      <= dm_next;
            s3_dy_reg      <= dy_next;
        end
    end

    // stage 4: saturation, status select, output register
    logic                 out_valid_reg;
    status_t              status_reg;
    logic [AGO_W-1:0]     ago_reg;
    logic [DAY_W-1:0]     dd_reg;
    logic [MONTH_W-1:0]   dm_reg;
    logic [YEAR_W-1:0]    dy_reg;

    status_t              status_next;
    logic [AGO_W-1:0]     ago_next;
    logic [DAY_W-1:0]     dd_out_next;
    logic [MONTH_W-1:0]   dm_out_next;
    logic [YEAR_W-1:0]    dy_out_next;

    always_comb
    begin
        logic [AGO_W-1:0] ago_sat;

        if (s3_sum_reg[SUM_W-1] || (s3_sum_reg == '0))
        begin
            ago_sat = '0;
        end
        else if (s3_sum_reg > SUM_W'(AGO_MAX))
        begin
            ago_sat = AGO_MAX;
        end
        else
        begin
            ago_sat = s3_sum_reg[AGO_W-1:0];
        end

        status_next = ST_INVALID;
        ago_next    = '0;
        dd_out_next = '0;
        dm_out_next = '0;
        dy_out_next = '0;
        priority if (!s3_ok_reg)
        begin
            status_next = ST_INVALID;
        end
        else if (s3_earlier_reg)
        begin
            status_next = ST_EXPIRED;
            ago_next    = ago_sat;
        end
        else if (s3_same_reg)
        begin
            status_next = ST_TODAY;
        end
        else
        begin
            status_next = ST_LATER;
            dd_out_next = s3_dd_reg;
            dm_out_next = s3_dm_reg;
            dy_out_next = s3_dy_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg <= status_next;
            ago_reg    <= ago_next;
            dd_reg     <= dd_out_next;
            dm_reg     <= dm_out_next;
            dy_reg     <= dy_out_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign days_ago    = ago_reg;
    assign diff_days   = dd_reg;
    assign diff_months = dm_reg;
    assign diff_years  = dy_reg;

endmodule

/* rtl/date_expiry_difference.sv */
`timescale 1ns / 1ps

// Compares each requested expiry date with today's date held in three
// configuration registers (day, month, year at indexes 0, 1, 2; reset is
// 2000-01-01) and returns one result per request: invalid (year outside
// 1800..9999, month outside 1..12 or day outside 1 to the Gregorian month
// length), expired with the day count since expiry (saturating at 4194303),
// today, or later with the remaining years, months and days. The datapath is
// a four-stage pipeline (divide-by-100 multipliers, calendar checks and month
// borrow, day sum and month split, saturation and output register): a new
// request enters every cycle unless a valid output is stalled, in which case
// the whole pipeline holds. Write today's date only while no request is in
// flight.
module date_expiry_difference
    import ded_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [DAY_W-1:0]      expiry_day,
    input  logic [MONTH_W-1:0]    expiry_month,
    input  logic [YEAR_W-1:0]     expiry_year,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [STATUS_W-1:0]   status,
    output logic [AGO_W-1:0]      days_ago,
    output logic [DAY_W-1:0]      diff_days,
    output logic [MONTH_W-1:0]    diff_months,
    output logic [YEAR_W-1:0]     diff_years
);

    today_t  today;
    logic    advance;
    logic    cal_valid;
    cal_t    cal;

    assign advance  = !out_valid || !out_stall;
    assign in_stall = !advance;

    ded_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .today     (today)
    );

    ded_calendar u_calendar (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .in_valid     (in_valid),
        .expiry_day   (expiry_day),
        .expiry_month (expiry_month),
        .expiry_year  (expiry_year),
        .today        (today),
        .cal_valid    (cal_valid),
        .cal          (cal)
    );

    ded_diff u_diff (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .cal_valid   (cal_valid),
        .cal         (cal),
        .today       (today),
        .out_valid   (out_valid),
        .status      (status),
        .days_ago    (days_ago),
        .diff_days   (diff_days),
        .diff_months (diff_months),
        .diff_years  (diff_years)
    );

endmodule
